@@ src/bsfr_pkg.sv @@
// Package for the byte-stuffed frame receiver.
// Holds link symbols, event codes, receive phase and the state/result structs.
// No dependencies.
package bsfr_pkg;

    localparam int BUFFER_DEPTH = 1024;
    localparam int COUNT_W      = $clog2(BUFFER_DEPTH + 1);
    localparam int LEN_W        = 10;

    localparam logic [7:0] SYM_HEADER = 8'h7D;
    localparam logic [7:0] SYM_END    = 8'h7E;
    localparam logic [7:0] SYM_ESCAPE = 8'h7F;
    localparam logic [7:0] CODE_FIRST = 8'h01;
    localparam logic [7:0] CODE_LAST  = 8'h03;

    localparam logic [7:0] TYPE_ACK  = 8'd0;
    localparam logic [7:0] TYPE_DATA = 8'd1;
    localparam logic [7:0] TYPE_CMD  = 8'd2;

    localparam logic [2:0] EV_DATA  = 3'd0;
    localparam logic [2:0] EV_END   = 3'd1;
    localparam logic [2:0] EV_ACK   = 3'd2;
    localparam logic [2:0] EV_CMD   = 3'd3;
    localparam logic [2:0] EV_ABORT = 3'd4;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_BEGIN   = 2'd1,
        PH_ESCAPE  = 2'd2,
        PH_PAYLOAD = 2'd3
    } phase_t;

    typedef struct packed {
        phase_t               phase;
        logic [7:0]           frame_type;
        logic [COUNT_W-1:0]   stored_count;
        logic [7:0]           command_arg;
    } rx_state_t;

    typedef struct packed {
        logic             valid;
        logic [2:0]       event_res;
        logic [7:0]       value;
        logic [LEN_W-1:0] frame_length;
    } rx_result_t;

endpackage

@@ src/bsfr_decode.sv @@
// Per-byte decode of the frame receiver: current state and one link byte
// in, next state and at most one result out. Uses bsfr_pkg.
module bsfr_decode
(
    input  bsfr_pkg::rx_state_t  state,
    input  logic [7:0]           rx_byte,
    output bsfr_pkg::rx_state_t  state_next,
    output bsfr_pkg::rx_result_t result
);

    logic       take;
    logic [7:0] dec_byte;

    always_comb
    begin
        state_next = state;
        result     = '0;
        take       = 1'b0;
        dec_byte   = rx_byte;

        if (state.phase == bsfr_pkg::PH_IDLE)
        begin
            if (rx_byte == bsfr_pkg::SYM_HEADER)
            begin
                state_next = '{bsfr_pkg::PH_BEGIN, 8'd0, '0, 8'd0};
            end
        end
        else if (rx_byte == bsfr_pkg::SYM_HEADER)
        begin
            // header inside a frame: abort and reopen
            state_next       = '{bsfr_pkg::PH_BEGIN, 8'd0, '0, 8'd0};
            result.valid     = 1'b1;
            result.event_res = bsfr_pkg::EV_ABORT;
        end
        else if (state.phase == bsfr_pkg::PH_ESCAPE)
        begin
            if (rx_byte >= bsfr_pkg::CODE_FIRST && rx_byte <= bsfr_pkg::CODE_LAST)
            begin
                take     = 1'b1;
                dec_byte = bsfr_pkg::SYM_HEADER + rx_byte - bsfr_pkg::CODE_FIRST;
            end
            else
            begin
                state_next.phase = bsfr_pkg::PH_IDLE;
                result.valid     = 1'b1;
                result.event_res = bsfr_pkg::EV_ABORT;
            end
        end
        else if (rx_byte == bsfr_pkg::SYM_END)
        begin
            state_next.phase = bsfr_pkg::PH_IDLE;
            if (state.stored_count == '0)
            begin
                result.valid     = 1'b1;
                result.event_res = bsfr_pkg::EV_ABORT;
            end
            else if (state.frame_type == bsfr_pkg::TYPE_ACK)
            begin
                result.valid     = 1'b1;
                result.event_res = bsfr_pkg::EV_ACK;
            end
            else if (state.frame_type == bsfr_pkg::TYPE_DATA)
            begin
                result.valid        = 1'b1;
                result.event_res    = bsfr_pkg::EV_END;
                result.frame_length = bsfr_pkg::LEN_W'(state.stored_count - 1'b1);
            end
            else if (state.frame_type == bsfr_pkg::TYPE_CMD)
            begin
                result.valid     = 1'b1;
                result.event_res = bsfr_pkg::EV_CMD;
                result.value     = (state.stored_count >= bsfr_pkg::COUNT_W'(2))
                                   ? state.command_arg : 8'd0;
            end
        end
        else if (rx_byte == bsfr_pkg::SYM_ESCAPE)
        begin
            state_next.phase = bsfr_pkg::PH_ESCAPE;
        end
        else
        begin
            take = 1'b1;
        end

        if (take)
        begin
            if (state.stored_count >= bsfr_pkg::COUNT_W'(bsfr_pkg::BUFFER_DEPTH))
            begin
                // overflow
                state_next.phase = bsfr_pkg::PH_IDLE;
                result.valid     = 1'b1;
                result.event_res = bsfr_pkg::EV_ABORT;
            end
            else
            begin
                if (state.stored_count == '0)
                begin
                    state_next.frame_type = dec_byte;
                end
                else
                begin
                    if (state.stored_count == bsfr_pkg::COUNT_W'(1))
                    begin
                        state_next.command_arg = dec_byte;
                    end
                    if (state.frame_type == bsfr_pkg::TYPE_DATA)
                    begin
                        result.valid     = 1'b1;
                        result.event_res = bsfr_pkg::EV_DATA;
                        result.value     = dec_byte;
                    end
                end
                state_next.stored_count = state.stored_count + 1'b1;
                state_next.phase        = bsfr_pkg::PH_PAYLOAD;
            end
        end
    end

endmodule

@@ src/byte_stuffed_frame_receiver.sv @@
// Byte-stuffed frame receiver, top level: input register, decode, result register.
// Depends on bsfr_pkg and bsfr_decode.
//
//  channel | handshake             | payload
//  --------+-----------------------+-------------------------------------
//  bytes   | byte_valid/byte_ready | rx_byte
//  results | res_valid/res_ready   | event_res, value, frame_length
//
// One byte per cycle sustained while results are taken; an accepted byte goes into the
// input register, is decoded against the frame state when the decode stage advances,
// and its result (if any) lands in the result register.
// A stalled result holds the decode stage; one further byte is still taken.
// rst_n clears the frame state to idle and both stages to empty.
module byte_stuffed_frame_receiver
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_ready,
    input  logic [7:0]  rx_byte,
    output logic        res_valid,
    input  logic        res_ready,
    output logic [2:0]  event_res,
    output logic [7:0]  value,
    output logic [bsfr_pkg::LEN_W-1:0] frame_length
);

    logic                 in_valid_reg;
    logic [7:0]           in_byte_reg;
    bsfr_pkg::rx_state_t  state_reg;
    bsfr_pkg::rx_state_t  state_next;
    bsfr_pkg::rx_result_t dec_result;
    logic                 res_valid_reg;
    logic [2:0]           res_event_reg;
    logic [7:0]           res_value_reg;
    logic [bsfr_pkg::LEN_W-1:0] res_length_reg;
    logic                 advance;

    bsfr_decode u_decode
    (
        .state      (state_reg),
        .rx_byte    (in_byte_reg),
        .state_next (state_next),
        .result     (dec_result)
    );

    assign advance    = in_valid_reg && (!res_valid_reg || res_ready);
    assign byte_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            state_reg     <= '{bsfr_pkg::PH_IDLE, 8'd0, '0, 8'd0};
        end
        else
        begin
            if (byte_ready)
            begin
                in_valid_reg <= byte_valid;
            end
            if (advance)
            begin
                state_reg     <= state_next;
                res_valid_reg <= dec_result.valid;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && byte_ready)
        begin
            in_byte_reg <= rx_byte;
        end
        if (advance && dec_result.valid)
        begin
            res_event_reg  <= dec_result.event_res;
            res_value_reg  <= dec_result.value;
            res_length_reg <= dec_result.frame_length;
        end
    end

    assign res_valid    = res_valid_reg;
    assign event_res    = res_event_reg;
    assign value        = res_value_reg;
    assign frame_length = res_length_reg;

endmodule

@@ src/bsfr_checker.sv @@
// Port-level checks for the byte-stuffed frame receiver, bound to the top level.
// Depends on bsfr_pkg.
module bsfr_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_ready,
    input logic [2:0]  event_res,
    input logic [7:0]  value,
    input logic [bsfr_pkg::LEN_W-1:0] frame_length
);

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(event_res))
        else $error("result dropped or changed while stalled");

    a_event_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> event_res <= bsfr_pkg::EV_ABORT)
        else $error("event code out of range");

    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && event_res != bsfr_pkg::EV_DATA && event_res != bsfr_pkg::EV_CMD
        |-> value == 8'd0)
        else $error("value not zero for this event");

    a_length_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && event_res != bsfr_pkg::EV_END |-> frame_length == '0)
        else $error("frame length not zero for this event");

endmodule

bind byte_stuffed_frame_receiver bsfr_checker u_bsfr_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .event_res    (event_res),
    .value        (value),
    .frame_length (frame_length)
);

@@ sim/tb_byte_stuffed_frame_receiver.sv @@
`timescale 1ns / 1ps
// Testbench for byte_stuffed_frame_receiver: directed stimulus table, then random frames.
// Results are checked against a built-in frame decoder. Depends on bsfr_pkg and the RTL.
module tb_byte_stuffed_frame_receiver;

    localparam int ITEMS_TARGET = 1200;
    localparam int LONG_AFTER   = 200;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DIR_ROWS     = 28;

    typedef enum logic [1:0] {ROW_PREDICT, ROW_NONE, ROW_EVENT} row_kind_t;
    typedef enum int {FLT_NONE, FLT_BAD_ESCAPE, FLT_HEADER, FLT_ESC_END, FLT_EMPTY} fault_t;

    typedef struct packed {
        row_kind_t                  kind;
        logic [7:0]                 rx;
        logic [2:0]                 ev;
        logic [7:0]                 val;
        logic [bsfr_pkg::LEN_W-1:0] len;
    } dir_row_t;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       byte_valid;
    logic                       byte_ready;
    logic [7:0]                 rx_byte;
    logic                       res_valid;
    logic                       res_ready;
    logic [2:0]                 event_res;
    logic [7:0]                 value;
    logic [bsfr_pkg::LEN_W-1:0] frame_length;

    bsfr_pkg::rx_state_t  dec;
    bsfr_pkg::rx_result_t pending_events [$];
    int         sent_items = 0;
    int         mismatches = 0;
    int         cycles = 0;
    logic       hold_request = 1'b0;
    logic       quiet;

    dir_row_t dir_table [DIR_ROWS] = '{
        '{ROW_NONE,    8'h00, bsfr_pkg::EV_DATA,  8'h00, '0},   // ignored while idle
        '{ROW_NONE,    8'hFF, bsfr_pkg::EV_DATA,  8'h00, '0},
        '{ROW_PREDICT, 8'h7D, bsfr_pkg::EV_DATA,  8'h00, '0},
        '{ROW_EVENT,   8'h7E, bsfr_pkg::EV_ABORT, 8'h00, '0},   // empty frame
        '{ROW_PREDICT, 8'h7D, bsfr_pkg::EV_DATA,  8'h00, '0},
        '{ROW_PREDICT, 8'h00, bsfr_pkg::EV_DATA,  8'h00, '0},
        '{ROW_EVENT,   8'h7E, bsfr_pkg::EV_ACK,   8'h00, '0},
        '{ROW_PREDICT, 8'h7D, bsfr_pkg::EV_DATA,  8'h00, '0},
        '{ROW_PREDICT, 8'h01, bsfr_pkg::EV_DATA,  8'h00, '0},
        '{ROW_PREDICT, 8'h7F, bsfr_pkg::EV_DATA,  8'h00, '0},
        '{ROW_PREDICT, 8'h01, bsfr_pkg::EV_DATA,  8'h00, '0},
        '{ROW_PREDICT, 8'h7F, bsfr_pkg::EV_DATA,  8'h00, '0},
        '{ROW_PREDICT, 8'h02, bsfr_pkg::EV_DATA,  8'h00, '0},
        '{ROW_PREDICT, 8'h7F, bsfr_pkg::EV_DATA,  8'h00, '0},
        '{ROW_PREDICT, 8'h03, bsfr_pkg::EV_DATA,  8'h00, '0},
        '{ROW_PREDICT, 8'hFF, bsfr_pkg::EV_DATA,  8'h00, '0},
        '{ROW_PREDICT, 8'h7E, bsfr_pkg::EV_DATA,  8'h00, '0},
        '{ROW_PREDICT, 8'h7D, bsfr_pkg::EV_DATA,  8'h00, '0},
        '{ROW_PREDICT, 8'h02, bsfr_pkg::EV_DATA,  8'h00, '0},
        '{ROW_EVENT,   8'h7E, bsfr_pkg::EV_CMD,   8'h00, '0},   // command, no argument
        '{ROW_PREDICT, 8'h7D, bsfr_pkg::EV_DATA,  8'h00, '0},
        '{ROW_PREDICT, 8'h7F, bsfr_pkg::EV_DATA,  8'h00, '0},
        '{ROW_EVENT,   8'h04, bsfr_pkg::EV_ABORT, 8'h00, '0},   // bad escape code
        '{ROW_PREDICT, 8'h7D, bsfr_pkg::EV_DATA,  8'h00, '0},
        '{ROW_PREDICT, 8'h01, bsfr_pkg::EV_DATA,  8'h00, '0},
        '{ROW_EVENT,   8'h7D, bsfr_pkg::EV_ABORT, 8'h00, '0},   // header inside frame
        '{ROW_PREDICT, 8'h03, bsfr_pkg::EV_DATA,  8'h00, '0},   // unknown type
        '{ROW_PREDICT, 8'h7E, bsfr_pkg::EV_DATA,  8'h00, '0}
    };

    byte_stuffed_frame_receiver uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_ready   (byte_ready),
        .rx_byte      (rx_byte),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .event_res    (event_res),
        .value        (value),
        .frame_length (frame_length)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL byte_stuffed_frame_receiver");
            $finish;
        end
    end

    assign quiet = (cycles >= 1500) && (cycles < 3000);

    function automatic bsfr_pkg::rx_result_t event_of(input logic [2:0] ev,
                                                      input logic [7:0] val,
                                                      input logic [bsfr_pkg::LEN_W-1:0] len);
        bsfr_pkg::rx_result_t r;
        r.valid        = 1'b1;
        r.event_res    = ev;
        r.value        = val;
        r.frame_length = len;
        return r;
    endfunction

    function automatic void open_frame();
        dec.phase        = bsfr_pkg::PH_BEGIN;
        dec.frame_type   = '0;
        dec.stored_count = '0;
        dec.command_arg  = '0;
    endfunction

    function automatic bsfr_pkg::rx_result_t store_byte(input logic [7:0] d);
        bsfr_pkg::rx_result_t r;
        r = '0;
        if (dec.stored_count >= bsfr_pkg::BUFFER_DEPTH)
        begin
            dec.phase = bsfr_pkg::PH_IDLE;
            return event_of(bsfr_pkg::EV_ABORT, 8'h00, '0);
        end
        if (dec.stored_count == 0)
            dec.frame_type = d;
        else
        begin
            if (dec.stored_count == 1)
                dec.command_arg = d;
            if (dec.frame_type == bsfr_pkg::TYPE_DATA)
                r = event_of(bsfr_pkg::EV_DATA, d, '0);
        end
        dec.stored_count = dec.stored_count + 1'b1;
        dec.phase = bsfr_pkg::PH_PAYLOAD;
        return r;
    endfunction

    function automatic bsfr_pkg::rx_result_t decode_byte(input logic [7:0] b);
        bsfr_pkg::rx_result_t r;
        r = '0;
        if (dec.phase == bsfr_pkg::PH_IDLE)
        begin
            if (b == bsfr_pkg::SYM_HEADER)
                open_frame();
            return r;
        end
        if (b == bsfr_pkg::SYM_HEADER)
        begin
            open_frame();
            return event_of(bsfr_pkg::EV_ABORT, 8'h00, '0);
        end
        if (dec.phase == bsfr_pkg::PH_ESCAPE)
        begin
            if (b >= bsfr_pkg::CODE_FIRST && b <= bsfr_pkg::CODE_LAST)
                return store_byte(bsfr_pkg::SYM_HEADER + b - bsfr_pkg::CODE_FIRST);
            dec.phase = bsfr_pkg::PH_IDLE;
            return event_of(bsfr_pkg::EV_ABORT, 8'h00, '0);
        end
        if (b == bsfr_pkg::SYM_END)
        begin
            dec.phase = bsfr_pkg::PH_IDLE;
            if (dec.stored_count == 0)
                return event_of(bsfr_pkg::EV_ABORT, 8'h00, '0);
            case (dec.frame_type)
                bsfr_pkg::TYPE_ACK:
                    return event_of(bsfr_pkg::EV_ACK, 8'h00, '0);
                bsfr_pkg::TYPE_DATA:
                    return event_of(bsfr_pkg::EV_END, 8'h00,
                                    bsfr_pkg::LEN_W'(dec.stored_count - 1'b1));
                bsfr_pkg::TYPE_CMD:
                    return event_of(bsfr_pkg::EV_CMD,
                                    dec.stored_count >= 2 ? dec.command_arg : 8'h00, '0);
                default:
                    return r;
            endcase
        end
        if (b == bsfr_pkg::SYM_ESCAPE)
        begin
            dec.phase = bsfr_pkg::PH_ESCAPE;
            return r;
        end
        return store_byte(b);
    endfunction

    task automatic note_mismatch(input string msg);
        $display("cycle %0d: mismatch: %s", cycles, msg);
        mismatches++;
    endtask

    task automatic check_result();
        bsfr_pkg::rx_result_t want;
        if (pending_events.size() == 0)
        begin
            note_mismatch($sformatf("event %0d with nothing pending", event_res));
            return;
        end
        want = pending_events.pop_front();
        if (event_res !== want.event_res)
            note_mismatch($sformatf("event_res %0d, want %0d", event_res, want.event_res));
        if (value !== want.value)
            note_mismatch($sformatf("value %02h, want %02h", value, want.value));
        if (frame_length !== want.frame_length)
            note_mismatch($sformatf("frame_length %0d, want %0d",
                                    frame_length, want.frame_length));
    endtask

    // result side: check at the rising edge, drive ready at the falling edge
    initial
    begin
        logic hold_taken;
        int   hold_left;
        hold_taken = 1'b0;
        hold_left  = 0;
        res_ready  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_valid && res_ready)
                check_result();
            @(negedge clk);
            if (hold_request && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ready <= 1'b0;
            end
            else
                res_ready <= quiet || ($urandom_range(0, 99) >= 24);
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_byte(input logic [7:0] b, output bsfr_pkg::rx_result_t r);
        while (!quiet && $urandom_range(0, 99) < 24)
        begin
            byte_valid <= 1'b0;
            @(negedge clk);
        end
        byte_valid <= 1'b1;
        rx_byte    <= b;
        do @(posedge clk); while (!byte_ready);
        sent_items++;
        r = decode_byte(b);
        @(negedge clk);
    endtask

    task automatic send_predicted(input logic [7:0] b);
        bsfr_pkg::rx_result_t r;
        send_byte(b, r);
        if (r.valid)
            pending_events.push_back(r);
    endtask

    task automatic send_decoded(input logic [7:0] d);
        if (d >= bsfr_pkg::SYM_HEADER && d <= bsfr_pkg::SYM_ESCAPE)
        begin
            send_predicted(bsfr_pkg::SYM_ESCAPE);
            send_predicted(d - bsfr_pkg::SYM_HEADER + bsfr_pkg::CODE_FIRST);
        end
        else
            send_predicted(d);
    endtask

    function automatic logic [7:0] random_data();
        if ($urandom_range(0, 7) == 0)
            return 8'(bsfr_pkg::SYM_HEADER + $urandom_range(0, 2));
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_frame(input int payload_len, input logic [7:0] ftype,
                              input logic allow_fault);
        fault_t     fault;
        int         at;
        logic [7:0] code;
        fault = FLT_NONE;
        if (allow_fault && $urandom_range(0, 99) < 15)
            fault = fault_t'($urandom_range(1, 4));
        send_predicted(bsfr_pkg::SYM_HEADER);
        if (fault == FLT_EMPTY)
        begin
            send_predicted(bsfr_pkg::SYM_END);
            return;
        end
        at = $urandom_range(0, payload_len);
        send_decoded(ftype);
        for (int i = 0; i <= payload_len; i++)
        begin
            if (fault != FLT_NONE && i == at)
            begin
                case (fault)
                    FLT_BAD_ESCAPE:
                    begin
                        do code = 8'($urandom_range(0, 255));
                        while (code >= bsfr_pkg::CODE_FIRST && code <= bsfr_pkg::CODE_LAST);
                        send_predicted(bsfr_pkg::SYM_ESCAPE);
                        send_predicted(code);
                        return;
                    end
                    FLT_ESC_END:
                    begin
                        send_predicted(bsfr_pkg::SYM_ESCAPE);
                        send_predicted(bsfr_pkg::SYM_END);
                        return;
                    end
                    default:
                        send_predicted(bsfr_pkg::SYM_HEADER);   // rest of frame reopens it
                endcase
            end
            if (i < payload_len)
                send_decoded(random_data());
        end
        send_predicted(bsfr_pkg::SYM_END);
    endtask

    initial
    begin
        bsfr_pkg::rx_result_t r;
        logic [7:0] ftype;
        logic [7:0] noise;
        int         pick;
        logic       long_done;
        long_done  = 1'b0;
        rst_n      = 1'b0;
        byte_valid = 1'b0;
        rx_byte    = 8'h00;
        dec.phase        = bsfr_pkg::PH_IDLE;
        dec.frame_type   = '0;
        dec.stored_count = '0;
        dec.command_arg  = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            send_byte(dir_table[i].rx, r);
            case (dir_table[i].kind)
                ROW_PREDICT:
                    if (r.valid)
                        pending_events.push_back(r);
                ROW_EVENT:
                    pending_events.push_back(event_of(dir_table[i].ev, dir_table[i].val,
                                                      dir_table[i].len));
                default: ;
            endcase
        end

        while (sent_items < ITEMS_TARGET)
        begin
            if (!long_done && sent_items >= LONG_AFTER)
            begin
                // data frame one byte past the buffer, under a long result stall
                long_done    = 1'b1;
                hold_request = 1'b1;
                send_predicted(bsfr_pkg::SYM_HEADER);
                send_predicted(bsfr_pkg::TYPE_DATA);
                for (int i = 0; i < bsfr_pkg::BUFFER_DEPTH - 1; i++)
                    send_predicted(8'($urandom_range(0, 8'h7C)));
                send_decoded(random_data());
                send_predicted(bsfr_pkg::SYM_END);
            end
            pick = $urandom_range(0, 99);
            if (pick < 40)
                ftype = bsfr_pkg::TYPE_DATA;
            else if (pick < 60)
                ftype = bsfr_pkg::TYPE_CMD;
            else if (pick < 72)
                ftype = bsfr_pkg::TYPE_ACK;
            else
                ftype = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 99) < 90)
                send_frame($urandom_range(0, 10), ftype, 1'b1);
            else
                send_frame($urandom_range(11, 60), ftype, 1'b1);
            repeat ($urandom_range(0, 3))
            begin
                noise = 8'($urandom_range(0, 255));
                if (noise == bsfr_pkg::SYM_HEADER)
                    noise = 8'h00;
                send_predicted(noise);
            end
        end

        byte_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("PASS byte_stuffed_frame_receiver");
        else
            $display("FAIL byte_stuffed_frame_receiver");
        $finish;
    end

endmodule

@@ files.f @@
src/bsfr_pkg.sv
src/bsfr_decode.sv
src/byte_stuffed_frame_receiver.sv
src/bsfr_checker.sv
sim/tb_byte_stuffed_frame_receiver.sv
